// ----- hw/rtl/assert_macros.svh -----
// Assertion helper macros shared by the RTL files that carry checks.
// No dependencies; the including module must have clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/aesc_pkg.sv -----
// Shared types, constants and SGR decode for the ANSI escape stripper.
// No dependencies; imported by the parser, the SGR scan and the top level.
`timescale 1ns / 1ps

package aesc_pkg;

  // Sizing
  localparam int MAX_PARAMS    = 16;
  localparam int POSITION_BITS = 16;
  localparam int PARAM_W       = 8;
  localparam int PCW           = $clog2(MAX_PARAMS + 1);
  localparam int PAW           = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
  localparam int CODE_W        = 4;
  localparam int COLOR_W       = 3;
  localparam int OUT_FIELDS_W  = 8 + CODE_W + COLOR_W + POSITION_BITS;
  localparam int OUT_DW        = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Byte codes
  localparam logic [7:0] B_NUL  = 8'h00;
  localparam logic [7:0] B_BEL  = 8'h07;
  localparam logic [7:0] B_ESC  = 8'h1b;
  localparam logic [7:0] B_CSI8 = 8'h9b;
  localparam logic [7:0] B_ST   = 8'h9c;
  localparam logic [7:0] B_LBRK = 8'h5b;
  localparam logic [7:0] B_RBRK = 8'h5d;
  localparam logic [7:0] B_DCS  = 8'h50;
  localparam logic [7:0] B_PM   = 8'h5e;
  localparam logic [7:0] B_APC  = 8'h5f;
  localparam logic [7:0] B_SEMI = 8'h3b;
  localparam logic [7:0] B_NINE = 8'h39;
  localparam logic [7:0] B_ZERO = 8'h30;
  localparam logic [7:0] B_SGR  = 8'h6d;

  // Command codes
  localparam logic [CODE_W-1:0] CMD_FG        = 4'd0;
  localparam logic [CODE_W-1:0] CMD_BG        = 4'd1;
  localparam logic [CODE_W-1:0] CMD_RESET     = 4'd2;
  localparam logic [CODE_W-1:0] CMD_BOLD      = 4'd3;
  localparam logic [CODE_W-1:0] CMD_ITALIC    = 4'd4;
  localparam logic [CODE_W-1:0] CMD_UNDERLINE = 4'd5;
  localparam logic [CODE_W-1:0] CMD_INVERT    = 4'd6;
  localparam logic [CODE_W-1:0] CMD_NORMAL    = 4'd7;
  localparam logic [CODE_W-1:0] CMD_DEF_FG    = 4'd8;
  localparam logic [CODE_W-1:0] CMD_DEF_BG    = 4'd9;
  localparam logic [CODE_W-1:0] CMD_LAST      = CMD_DEF_BG;

  typedef enum logic [3:0] {
    M_GROUND,
    M_ESC,
    M_CSI_PARAM,
    M_CSI_INTER,
    M_OSC_START,
    M_OSC_NUM,
    M_OSC_STR,
    M_ST_STR,
    M_HALT
  } aesc_mode_t;

  typedef enum logic [1:0] {
    SC_IDLE,
    SC_READ,
    SC_EVAL,
    SC_FLUSH
  } aesc_scan_t;

  // Parameter store write
  typedef struct packed {
    logic               en;
    logic [PAW-1:0]     addr;
    logic [PARAM_W-1:0] data;
  } aesc_wr_t;

  // Text result from the parser
  typedef struct packed {
    logic                     valid;
    logic [7:0]               data;
    logic [POSITION_BITS-1:0] pos;
  } aesc_text_t;

  // Request to walk the stored parameters
  typedef struct packed {
    logic           valid;
    logic [PCW-1:0] count;
  } aesc_start_t;

  // Command result from the scanner
  typedef struct packed {
    logic               valid;
    logic [CODE_W-1:0]  code;
    logic [COLOR_W-1:0] color;
    logic               last;
  } aesc_cmd_t;

  typedef struct packed {
    logic               known;
    logic [CODE_W-1:0]  code;
    logic [COLOR_W-1:0] color;
  } aesc_sgr_t;

  // Map one parameter value to an SGR command
  function automatic aesc_sgr_t sgr_decode(input logic [PARAM_W-1:0] v);
    aesc_sgr_t r;
    r.known = 1'b1;
    r.code  = CMD_FG;
    r.color = '0;
    if (v inside {[8'd30:8'd37]}) begin
      r.code  = CMD_FG;
      r.color = v[COLOR_W-1:0] - 3'd6;  // 30 -> 0
    end else if (v inside {[8'd40:8'd47]}) begin
      r.code  = CMD_BG;
      r.color = v[COLOR_W-1:0];         // 40 is a multiple of 8
    end else begin
      case (v)
        8'd0:    r.code = CMD_RESET;
        8'd1:    r.code = CMD_BOLD;
        8'd3:    r.code = CMD_ITALIC;
        8'd4:    r.code = CMD_UNDERLINE;
        8'd7:    r.code = CMD_INVERT;
        8'd10:   r.code = CMD_NORMAL;
        8'd39:   r.code = CMD_DEF_FG;
        8'd49:   r.code = CMD_DEF_BG;
        default: r.known = 1'b0;
      endcase
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/aesc_param_ram.sv -----
// Generic single-port-write, registered-read RAM holding CSI parameters.
// No dependencies.
`timescale 1ns / 1ps

module aesc_param_ram #(
  parameter int  DEPTH = 16,
  parameter int  WIDTH = 8,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- hw/rtl/aesc_parser.sv -----
// Byte-level escape sequence parser: mode, current parameter, text position.
// Depends on aesc_pkg; writes the parameter store, starts the SGR scan.
`timescale 1ns / 1ps

module aesc_parser import aesc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     accept,
  input  logic [7:0]               data_byte,
  input  logic                     buffer_start,
  output aesc_wr_t                 wr,
  output aesc_text_t               text,
  output aesc_start_t              start,
  output logic [POSITION_BITS-1:0] text_count
);

  localparam logic [POSITION_BITS-1:0] POS_MAX   = '1;
  localparam logic [PCW-1:0]           COUNT_CAP = PCW'(MAX_PARAMS);

  aesc_mode_t               mode_r, mode_nxt;
  logic [PCW-1:0]           count_r, count_nxt;
  logic [PARAM_W-1:0]       cur_r, cur_nxt;
  logic                     has_r, has_nxt;
  logic                     done_r, done_nxt;
  logic [POSITION_BITS-1:0] text_r, text_nxt;

  // A buffer start clears the parse context before the byte is looked at
  aesc_mode_t               eff_mode;
  logic [PCW-1:0]           eff_count;
  logic [PARAM_W-1:0]       eff_cur;
  logic                     eff_has;
  logic                     eff_done;
  logic [POSITION_BITS-1:0] eff_text;

  assign eff_mode  = buffer_start ? M_GROUND : mode_r;
  assign eff_count = buffer_start ? '0 : count_r;
  assign eff_cur   = buffer_start ? '0 : cur_r;
  assign eff_has   = buffer_start ? 1'b0 : has_r;
  assign eff_done  = buffer_start ? 1'b0 : done_r;
  assign eff_text  = buffer_start ? '0 : text_r;

  // Byte classes
  logic b_esc, b_class, b_param, b_inter, b_final, b_osc_type, b_osc_num;
  logic in_csi, is_param, again, gmode;

  assign b_esc      = (data_byte == B_ESC) || (data_byte == B_CSI8);
  assign b_class    = data_byte inside {[8'h40:8'h5f]};
  assign b_param    = data_byte inside {[8'h30:8'h3f]};
  assign b_inter    = data_byte inside {[8'h20:8'h2f]};
  assign b_final    = data_byte inside {[8'h40:8'h7e]};
  assign b_osc_type = data_byte inside {[8'h60:8'h7e]};
  assign b_osc_num  = b_param;

  assign in_csi   = (eff_mode == M_CSI_PARAM) || (eff_mode == M_CSI_INTER);
  assign is_param = (eff_mode == M_CSI_PARAM) && b_param;

  // Bytes that end a sequence and are taken again as plain input
  assign again = ((eff_mode == M_ESC) && !b_class) ||
                 ((eff_mode == M_OSC_START) && !b_osc_type && !b_osc_num) ||
                 (in_csi && !is_param && !b_inter && !b_final);
  assign gmode = again || (eff_mode == M_GROUND);

  // Next parse mode
  always_comb begin
    mode_nxt = eff_mode;
    if (gmode) begin
      if (data_byte == B_NUL) begin
        mode_nxt = M_HALT;
      end else if (b_esc) begin
        mode_nxt = M_ESC;
      end else begin
        mode_nxt = M_GROUND;
      end
    end else begin
      case (eff_mode)
        M_ESC: begin
          if (data_byte == B_LBRK) begin
            mode_nxt = M_CSI_PARAM;
          end else if (data_byte == B_RBRK) begin
            mode_nxt = M_OSC_START;
          end else if ((data_byte == B_DCS) || (data_byte == B_PM) ||
                       (data_byte == B_APC)) begin
            mode_nxt = M_ST_STR;
          end else begin
            mode_nxt = M_GROUND;
          end
        end
        M_CSI_PARAM, M_CSI_INTER: begin
          if (is_param) begin
            mode_nxt = M_CSI_PARAM;
          end else if (b_inter) begin
            mode_nxt = M_CSI_INTER;
          end else begin
            mode_nxt = M_GROUND;
          end
        end
        M_OSC_START: begin
          if (b_osc_type) begin
            mode_nxt = M_ST_STR;
          end else begin
            mode_nxt = (data_byte == B_SEMI) ? M_OSC_STR : M_OSC_NUM;
          end
        end
        M_OSC_NUM: begin
          if (data_byte == B_SEMI) mode_nxt = M_OSC_STR;
        end
        M_OSC_STR: begin
          if (data_byte == B_BEL) mode_nxt = M_GROUND;
        end
        M_ST_STR: begin
          if (data_byte == B_ST) mode_nxt = M_GROUND;
        end
        default: mode_nxt = M_HALT;
      endcase
    end
  end

  // Parameter collection and outputs
  logic                push, room, csi_clear, digit, mark;
  logic [11:0]         acc;
  logic [PARAM_W-1:0]  acc_sat;

  assign push = (is_param && (data_byte == B_SEMI)) ||
                ((eff_mode == M_CSI_PARAM) && !is_param && eff_has);
  assign room      = eff_count < COUNT_CAP;
  assign csi_clear = (eff_mode == M_ESC) && (data_byte == B_LBRK);
  assign digit     = is_param && (data_byte <= B_NINE);
  assign mark      = is_param && (data_byte > B_NINE) && (data_byte != B_SEMI);

  // Decimal accumulate, saturating at the top of the parameter range
  assign acc     = ({4'd0, eff_cur} * 12'd10) + {4'd0, data_byte - B_ZERO};
  assign acc_sat = (acc > 12'd255) ? 8'hff : acc[PARAM_W-1:0];

  always_comb begin
    count_nxt = eff_count;
    cur_nxt   = eff_cur;
    has_nxt   = eff_has;
    done_nxt  = eff_done;
    text_nxt  = eff_text;
    if (csi_clear || again) begin
      count_nxt = '0;
    end else if (push && room) begin
      count_nxt = eff_count + 1'b1;
    end
    if (csi_clear || again || push) begin
      cur_nxt  = '0;
      has_nxt  = 1'b0;
      done_nxt = 1'b0;
    end else if (digit) begin
      if (!eff_done) cur_nxt = acc_sat;
      has_nxt = 1'b1;
    end else if (mark) begin
      has_nxt  = 1'b1;
      done_nxt = 1'b1;
    end
    if (text.valid && (eff_text != POS_MAX)) begin
      text_nxt = eff_text + 1'b1;
    end
  end

  assign wr.en    = accept && push && room;
  assign wr.addr  = eff_count[PAW-1:0];
  assign wr.data  = eff_cur;

  assign text.valid = accept && gmode && (data_byte != B_NUL) && !b_esc;
  assign text.data  = data_byte;
  assign text.pos   = eff_text;

  assign start.valid = accept && in_csi && !is_param && (data_byte == B_SGR) &&
                       (count_nxt != '0);
  assign start.count = count_nxt;

  assign text_count = text_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= M_GROUND;
      count_r <= '0;
      cur_r   <= '0;
      has_r   <= 1'b0;
      done_r  <= 1'b0;
      text_r  <= '0;
    end else if (accept) begin
      mode_r  <= mode_nxt;
      count_r <= count_nxt;
      cur_r   <= cur_nxt;
      has_r   <= has_nxt;
      done_r  <= done_nxt;
      text_r  <= text_nxt;
    end
  end

endmodule

// ----- hw/rtl/aesc_sgr_scan.sv -----
// Walks the stored CSI parameters after an 'm' final and emits SGR commands.
// Depends on aesc_pkg; reads the parameter store through its read port.
`timescale 1ns / 1ps

module aesc_sgr_scan import aesc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  aesc_start_t        start,
  input  logic               out_free,
  output logic               rd_en,
  output logic [PAW-1:0]     rd_addr,
  input  logic [PARAM_W-1:0] rd_data,
  output logic               busy,
  output aesc_cmd_t          cmd
);

  aesc_scan_t         state_r, state_nxt;
  logic [PCW-1:0]     idx_r;
  logic [PCW-1:0]     count_r;
  logic               hold_valid_r;
  logic [CODE_W-1:0]  hold_code_r;
  logic [COLOR_W-1:0] hold_color_r;

  aesc_sgr_t          dec;
  logic               stall;
  logic [PCW-1:0]     idx_inc;

  assign dec     = sgr_decode(rd_data);
  assign idx_inc = idx_r + 1'b1;
  // A new hit must wait until the held command can leave
  assign stall   = dec.known && hold_valid_r && !out_free;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      SC_IDLE:  if (start.valid) state_nxt = SC_READ;
      SC_READ:  state_nxt = SC_EVAL;
      SC_EVAL: begin
        if (!stall) state_nxt = (idx_inc == count_r) ? SC_FLUSH : SC_READ;
      end
      SC_FLUSH: if (!hold_valid_r || out_free) state_nxt = SC_IDLE;
      default:  state_nxt = SC_IDLE;
    endcase
  end

  // Outputs: the held command goes out once the next one, or the end, is known
  always_comb begin
    rd_en     = 1'b0;
    cmd.valid = 1'b0;
    cmd.last  = 1'b0;
    cmd.code  = hold_code_r;
    cmd.color = hold_color_r;
    case (state_r)
      SC_READ:  rd_en = 1'b1;
      SC_EVAL:  cmd.valid = dec.known && hold_valid_r && !stall;
      SC_FLUSH: begin
        cmd.valid = hold_valid_r && out_free;
        cmd.last  = 1'b1;
      end
      default: ;
    endcase
  end

  assign rd_addr   = idx_r[PAW-1:0];
  assign busy      = state_r != SC_IDLE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= SC_IDLE;
      hold_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == SC_EVAL) && !stall && dec.known) begin
        hold_valid_r <= 1'b1;
      end else if ((state_r == SC_FLUSH) && out_free) begin
        hold_valid_r <= 1'b0;
      end
    end
  end

  // Scan index and held command payload
  always_ff @(posedge clk) begin
    if ((state_r == SC_IDLE) && start.valid) begin
      idx_r   <= '0;
      count_r <= start.count;
    end else if ((state_r == SC_EVAL) && !stall) begin
      idx_r <= idx_inc;
    end
    if ((state_r == SC_EVAL) && !stall && dec.known) begin
      hold_code_r  <= dec.code;
      hold_color_r <= dec.color;
    end
  end

endmodule

// ----- hw/rtl/ansi_escape_stripper.sv -----
// Top level of the ANSI escape stripper: parser, parameter RAM, SGR scan.
// Depends on aesc_pkg, aesc_param_ram, aesc_parser, aesc_sgr_scan.
`timescale 1ns / 1ps

// Takes one terminal byte per transaction and returns the plain text with
// ANSI escape sequences removed, plus one command result for every known SGR
// code among the first 16 parameters of a CSI ... m sequence. Plain bytes
// stream at one per cycle while the result side keeps up; bytes inside
// sequences produce no result. CSI parameters are written to a 16-entry
// parameter RAM as they complete; an 'm' final then starts a scan of that RAM
// with one read port, each stored parameter read, then decoded, so such a
// byte blocks the input until the scan ends, longer if the result side
// stalls. One output register separates the two sides. The zero byte
// silences the stream until a transaction with buffer_start set.
module ansi_escape_stripper import aesc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,   // [7:0] data_byte
  input  logic [0:0]        in_tuser,   // [0] buffer_start
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_DW-1:0] out_tdata,  // text_byte, command_code, color_value,
                                        // text_position, zero pad
  output logic [0:0]        out_tuser,  // [0] is_command
  output logic              out_tlast   // last_of_run
);

  `include "assert_macros.svh"

  logic                     in_fire;
  logic                     out_free;
  logic                     scan_busy;
  aesc_wr_t                 wr;
  aesc_text_t               text;
  aesc_start_t              start;
  aesc_cmd_t                cmd;
  logic [POSITION_BITS-1:0] text_count;
  logic                     rd_en;
  logic [PAW-1:0]           rd_addr;
  logic [PARAM_W-1:0]       rd_data;

  // Output register
  logic                     out_valid_r;
  logic                     is_cmd_r;
  logic [7:0]               byte_r;
  logic [CODE_W-1:0]        code_r;
  logic [COLOR_W-1:0]       color_r;
  logic [POSITION_BITS-1:0] pos_r;
  logic                     last_r;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = !scan_busy && out_free;
  assign in_fire   = in_tvalid && in_tready;

  aesc_parser u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (in_fire),
    .data_byte    (in_tdata),
    .buffer_start (in_tuser[0]),
    .wr           (wr),
    .text         (text),
    .start        (start),
    .text_count   (text_count)
  );

  aesc_param_ram #(
    .DEPTH (MAX_PARAMS),
    .WIDTH (PARAM_W)
  ) u_param_ram (
    .clk     (clk),
    .wr_en   (wr.en),
    .wr_addr (wr.addr),
    .wr_data (wr.data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  aesc_sgr_scan u_sgr_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .out_free (out_free),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .busy     (scan_busy),
    .cmd      (cmd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (text.valid || cmd.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (text.valid) begin
      is_cmd_r <= 1'b0;
      byte_r   <= text.data;
      code_r   <= '0;
      color_r  <= '0;
      pos_r    <= text.pos;
      last_r   <= 1'b1;
    end else if (cmd.valid) begin
      is_cmd_r <= 1'b1;
      byte_r   <= '0;
      code_r   <= cmd.code;
      color_r  <= cmd.color;
      pos_r    <= text_count;
      last_r   <= cmd.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = is_cmd_r;
  assign out_tlast  = last_r;
  assign out_tdata  = OUT_DW'({pos_r, color_r, code_r, byte_r});

  // Checks
  `ASSERT_IMP(a_text_single, out_tvalid && !out_tuser[0], out_tlast,
              "text result without last_of_run")
  `ASSERT_IMP(a_text_no_cmd, out_tvalid && !out_tuser[0],
              (code_r == '0) && (color_r == '0), "text result carries command fields")
  `ASSERT_IMP(a_cmd_range, out_tvalid && out_tuser[0],
              (code_r <= CMD_LAST) && (byte_r == '0), "command result out of range")
  `ASSERT_CLK(a_no_wr_in_scan, !(scan_busy && wr.en),
              "parameter store written during SGR scan")

endmodule
